[rtl/core/xoshiro256pp_generator_macros.svh]
// ---------------------------------------------------------------------------
// xoshiro256pp_generator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef XOSHIRO256PP_GENERATOR_MACROS_SVH
`define XOSHIRO256PP_GENERATOR_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define XSR_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define XSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/xsr_pkg.sv]
// ---------------------------------------------------------------------------
// xsr_pkg
// Types, constants and helpers shared by the xoshiro256++ generator.
// ---------------------------------------------------------------------------
package xsr_pkg;

    localparam int unsigned WordW    = 64;
    localparam int unsigned HalfW    = WordW / 2;
    localparam int unsigned NumWords = 4;
    localparam int unsigned WordIdxW = 2;

    typedef logic [WordW-1:0]    t_word;
    typedef logic [HalfW-1:0]    t_half;
    typedef logic [WordIdxW-1:0] t_word_idx;

    // Input operation codes
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Seeding and step constants
    localparam t_word GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam t_word MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam t_word MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

    localparam int unsigned OUT_ROT     = 23;
    localparam int unsigned STEP_SHIFT  = 17;
    localparam int unsigned STEP_ROT    = 45;
    localparam int unsigned MIX_SHIFT_A = 30;
    localparam int unsigned MIX_SHIFT_B = 27;
    localparam int unsigned MIX_SHIFT_C = 31;

    localparam t_word_idx LAST_WORD_IDX = t_word_idx'(NumWords - 1);

    // Partial product codes of the iterative 64-bit multiplier
    typedef enum logic [1:0] {
        MUL_LO_LO,
        MUL_LO_HI,
        MUL_HI_LO
    } t_mul_step;

    // Seeding sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL_A,
        ST_MUL_B
    } t_state;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic      busy;
        logic      acc_step;
        logic      start_b;
        logic      word_we;
        t_word_idx word_idx;
    } t_ctrl;

    // Rotate left by a constant amount in 1..63
    function automatic t_word rotl(input t_word v, input int unsigned amt);
        rotl = (v << amt) | (v >> (WordW - amt));
    endfunction

endpackage

[rtl/core/xsr_mul64.sv]
// ---------------------------------------------------------------------------
// xsr_mul64
// Iterative 64x64 multiply, low 64 bits, on one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
`include "xoshiro256pp_generator_macros.svh"

module xsr_mul64 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  xsr_pkg::t_word i_op_a,
    input  xsr_pkg::t_word i_op_b,
    output logic          o_done,
    output xsr_pkg::t_word o_product
);

    xsr_pkg::t_word     r_a;
    xsr_pkg::t_word     r_b;
    xsr_pkg::t_word     r_prod;
    xsr_pkg::t_word     n_prod;
    xsr_pkg::t_mul_step r_step;
    xsr_pkg::t_mul_step n_step;
    logic               r_busy;
    logic               r_done;
    xsr_pkg::t_half     mul_x;
    xsr_pkg::t_half     mul_y;
    xsr_pkg::t_word     pp;
    logic               last_step;

    // select the partial product for this step
    always_comb begin
        case (r_step)
            xsr_pkg::MUL_LO_HI: begin
                mul_x = r_a[xsr_pkg::HalfW-1:0];
                mul_y = r_b[xsr_pkg::WordW-1:xsr_pkg::HalfW];
            end
            xsr_pkg::MUL_HI_LO: begin
                mul_x = r_a[xsr_pkg::WordW-1:xsr_pkg::HalfW];
                mul_y = r_b[xsr_pkg::HalfW-1:0];
            end
            default: begin
                mul_x = r_a[xsr_pkg::HalfW-1:0];
                mul_y = r_b[xsr_pkg::HalfW-1:0];
            end
        endcase
    end

    assign pp        = xsr_pkg::t_word'(mul_x) * xsr_pkg::t_word'(mul_y);
    assign last_step = (r_step == xsr_pkg::MUL_HI_LO);

    always_comb begin
        if (r_step == xsr_pkg::MUL_LO_LO) begin
            n_prod = pp;
        end else begin
            n_prod = r_prod + {pp[xsr_pkg::HalfW-1:0], xsr_pkg::t_half'(0)};
        end
        case (r_step)
            xsr_pkg::MUL_LO_LO: n_step = xsr_pkg::MUL_LO_HI;
            default:            n_step = xsr_pkg::MUL_HI_LO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_op_a;
            r_b <= i_op_b;
        end
        if (r_busy) begin
            r_prod <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= xsr_pkg::MUL_LO_LO;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= xsr_pkg::MUL_LO_LO;
            end else if (r_busy) begin
                r_step <= n_step;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_prod;

    `XSR_ASSERT_CLK(a_mul_start_idle, i_start |-> !r_busy, "multiply started while busy")
    `XSR_ASSERT_CLK(a_mul_latency, i_start |-> ##4 o_done, "multiply did not finish in time")

endmodule

[rtl/core/xsr_ctrl.sv]
// ---------------------------------------------------------------------------
// xsr_ctrl
// Sequencer for splitmix64 seeding: four words, two multiplies per word.
// ---------------------------------------------------------------------------
`include "xoshiro256pp_generator_macros.svh"

module xsr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_seed_go,
    input  logic          i_mul_done,
    output xsr_pkg::t_ctrl o_ctrl
);

    xsr_pkg::t_state    r_state;
    xsr_pkg::t_state    n_state;
    xsr_pkg::t_word_idx r_idx;
    xsr_pkg::t_word_idx n_idx;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xsr_pkg::ST_IDLE: begin
                if (i_seed_go) n_state = xsr_pkg::ST_STEP;
            end
            xsr_pkg::ST_STEP: begin
                n_state = xsr_pkg::ST_MUL_A;
            end
            xsr_pkg::ST_MUL_A: begin
                if (i_mul_done) n_state = xsr_pkg::ST_MUL_B;
            end
            xsr_pkg::ST_MUL_B: begin
                if (i_mul_done) begin
                    n_state = (r_idx == xsr_pkg::LAST_WORD_IDX) ? xsr_pkg::ST_IDLE
                                                                : xsr_pkg::ST_STEP;
                end
            end
            default: n_state = xsr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.word_idx = r_idx;
        unique case (r_state)
            xsr_pkg::ST_IDLE: o_ctrl.busy = 1'b0;
            xsr_pkg::ST_STEP: begin
                o_ctrl.busy     = 1'b1;
                o_ctrl.acc_step = 1'b1;
            end
            xsr_pkg::ST_MUL_A: begin
                o_ctrl.busy    = 1'b1;
                o_ctrl.start_b = i_mul_done;
            end
            xsr_pkg::ST_MUL_B: begin
                o_ctrl.busy    = 1'b1;
                o_ctrl.word_we = i_mul_done;
            end
            default: o_ctrl.busy = 1'b0;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (i_seed_go) begin
            n_idx = '0;
        end else if (o_ctrl.word_we) begin
            n_idx = r_idx + xsr_pkg::t_word_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // seed zero is expanded right out of reset
            r_state <= xsr_pkg::ST_STEP;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    `XSR_ASSERT_CLK(a_ctrl_strobes, $onehot0({o_ctrl.acc_step, o_ctrl.start_b, o_ctrl.word_we}),
        "more than one sequencer strobe active")
    `XSR_ASSERT_CLK(a_ctrl_go_idle, i_seed_go |-> (r_state == xsr_pkg::ST_IDLE),
        "reseed taken while seeding in progress")

endmodule

[rtl/core/xoshiro256pp_generator.sv]
// ---------------------------------------------------------------------------
// xoshiro256pp_generator
// xoshiro256++ generator with splitmix64 seeding, 64-bit draws.
// ---------------------------------------------------------------------------
// Each input beat is either a draw (operation 0) or a reseed (operation 1).
// On a draw the result lands in the output register and the 256-bit state
// advances on the same edge, so draws run back to back at one beat per cycle
// as long as the output side keeps taking beats. A reseed gives no output
// beat; it expands the seed into four state words with splitmix64, sharing
// one 32x32 multiplier that builds each 64-bit product from three partial
// products. Each word takes one increment step and two multiplies, and a
// reseed keeps o_stall high until the fourth word is written. The same
// expansion of seed zero runs right after reset, before the first beat is
// accepted.
// ---------------------------------------------------------------------------
`include "xoshiro256pp_generator_macros.svh"

module xoshiro256pp_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [63:0] i_seed_value,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_draw
);

    xsr_pkg::t_ctrl ctrl;
    xsr_pkg::t_word r_words [xsr_pkg::NumWords];
    xsr_pkg::t_word n_words [xsr_pkg::NumWords];
    xsr_pkg::t_word r_acc;
    xsr_pkg::t_word acc_sum;
    xsr_pkg::t_word mix_a_in;
    xsr_pkg::t_word mix_b_in;
    xsr_pkg::t_word seed_word;
    xsr_pkg::t_word mul_product;
    xsr_pkg::t_word mul_op_a;
    xsr_pkg::t_word mul_op_b;
    xsr_pkg::t_word draw_val;
    xsr_pkg::t_word r_draw;
    xsr_pkg::t_word t2;
    xsr_pkg::t_word t3;
    logic           r_out_valid;
    logic           mul_done;
    logic           in_accept;
    logic           out_accept;
    logic           draw_go;
    logic           seed_go;

    // Hold the input off while seeding, or while a draw waits downstream.
    assign o_stall    = ctrl.busy || (r_out_valid && i_stall);
    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_out_valid && !i_stall;
    assign draw_go    = in_accept && (i_operation == xsr_pkg::OP_DRAW);
    assign seed_go    = in_accept && (i_operation == xsr_pkg::OP_RESEED);

    xsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed_go  (seed_go),
        .i_mul_done (mul_done),
        .o_ctrl     (ctrl)
    );

    // splitmix64 datapath: advance the running seed, then two mix rounds
    assign acc_sum   = r_acc + xsr_pkg::GOLDEN_STEP;
    assign mix_a_in  = acc_sum ^ (acc_sum >> xsr_pkg::MIX_SHIFT_A);
    assign mix_b_in  = mul_product ^ (mul_product >> xsr_pkg::MIX_SHIFT_B);
    assign seed_word = mul_product ^ (mul_product >> xsr_pkg::MIX_SHIFT_C);
    assign mul_op_a  = ctrl.acc_step ? mix_a_in : mix_b_in;
    assign mul_op_b  = ctrl.acc_step ? xsr_pkg::MIX_MUL_A : xsr_pkg::MIX_MUL_B;

    xsr_mul64 u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ctrl.acc_step || ctrl.start_b),
        .i_op_a    (mul_op_a),
        .i_op_b    (mul_op_b),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    // xoshiro256++ output and state step
    assign draw_val = xsr_pkg::rotl(r_words[0] + r_words[3], xsr_pkg::OUT_ROT) + r_words[0];
    assign t2       = r_words[2] ^ r_words[0];
    assign t3       = r_words[3] ^ r_words[1];

    always_comb begin
        for (int i = 0; i < xsr_pkg::NumWords; i++) begin
            n_words[i] = r_words[i];
        end
        if (draw_go) begin
            n_words[0] = r_words[0] ^ t3;
            n_words[1] = r_words[1] ^ t2;
            n_words[2] = t2 ^ (r_words[1] << xsr_pkg::STEP_SHIFT);
            n_words[3] = xsr_pkg::rotl(t3, xsr_pkg::STEP_ROT);
        end else if (ctrl.word_we) begin
            n_words[ctrl.word_idx] = seed_word;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < xsr_pkg::NumWords; i++) begin
            r_words[i] <= n_words[i];
        end
        if (draw_go) begin
            r_draw <= draw_val;
        end
    end

    // running seed; starts at zero so reset expands seed zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (seed_go) begin
            r_acc <= i_seed_value;
        end else if (ctrl.acc_step) begin
            r_acc <= acc_sum;
        end
    end

    // output register: drop the beat when taken, load it on a draw
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (draw_go) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_draw  = r_draw;

    `XSR_ASSERT_NEXT(a_draw_gives_beat, draw_go, o_valid, "draw did not produce an output beat")
    `XSR_ASSERT_NEXT(a_seed_holds_input, seed_go, o_stall, "input not held during reseed")

endmodule

[test/draw_tracker_pkg.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// draw_tracker_pkg
// Predicts xoshiro256++ draws and tracks the ones still owed by the block.
// ---------------------------------------------------------------------------
package draw_tracker_pkg;

    import xsr_pkg::*;

    class draw_tracker;

        t_word       gen_state [NumWords];
        t_word       owed_draws [$];
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
            expand_seed('0);
        endfunction

        // All arithmetic wraps at 64 bits through the t_word width.
        function automatic t_word rot_left(t_word v, int unsigned amt);
            return (v << amt) | (v >> (WordW - amt));
        endfunction

        function void expand_seed(t_word seed);
            t_word acc;
            t_word z;
            acc = seed;
            for (int i = 0; i < NumWords; i++) begin
                acc = acc + GOLDEN_STEP;
                z   = acc;
                z   = (z ^ (z >> MIX_SHIFT_A)) * MIX_MUL_A;
                z   = (z ^ (z >> MIX_SHIFT_B)) * MIX_MUL_B;
                gen_state[i] = z ^ (z >> MIX_SHIFT_C);
            end
        endfunction

        function t_word next_draw();
            t_word result;
            t_word spill;
            result = rot_left(gen_state[0] + gen_state[3], OUT_ROT) + gen_state[0];
            spill  = gen_state[1] << STEP_SHIFT;
            gen_state[2] ^= gen_state[0];
            gen_state[3] ^= gen_state[1];
            gen_state[1] ^= gen_state[2];
            gen_state[0] ^= gen_state[3];
            gen_state[2] ^= spill;
            gen_state[3] = rot_left(gen_state[3], STEP_ROT);
            return result;
        endfunction

        // Record an accepted input beat; only a draw owes an output beat.
        function void note_beat(logic op, t_word seed);
            if (op == OP_RESEED) begin
                expand_seed(seed);
            end else begin
                owed_draws.push_back(next_draw());
            end
        endfunction

        function void check_draw(t_word actual);
            t_word want;
            if (owed_draws.size() == 0) begin
                $display("%0t: unexpected draw, expected none, actual %h", $time, actual);
                mismatch_count++;
            end else begin
                want = owed_draws.pop_front();
                if (want !== actual) begin
                    $display("%0t: draw mismatch, expected %h, actual %h",
                             $time, want, actual);
                    mismatch_count++;
                end
            end
        endfunction

        function int unsigned outstanding();
            return owed_draws.size();
        endfunction

        function void flag_leftovers();
            foreach (owed_draws[i]) begin
                $display("%0t: draw never came, expected %h, actual none",
                         $time, owed_draws[i]);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage

[test/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Random and directed regression of the xoshiro256++ generator.
// ---------------------------------------------------------------------------
// A stream of draw and reseed beats goes into the block with random gaps,
// while the output side stalls at random. Every accepted input beat is fed to
// a software copy of the generator, which queues the draw it owes; every
// accepted output beat is compared with the oldest owed draw. The receiver
// holds off for long stretches twice so the output register backs up and the
// block stalls its input, and the sender drains the block fully three times.
// ---------------------------------------------------------------------------
module testbench;

    import xsr_pkg::*;
    import draw_tracker_pkg::*;

    localparam int unsigned RANDOM_BEATS = 1750;
    localparam int unsigned HOLD_CYCLES  = 300;
    // A reseed keeps the input stalled while it expands the seed; wait longer
    // than that at the end so a stray beat would still show up.
    localparam int unsigned SETTLE_CYCLES = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_operation;
    logic [63:0] i_seed_value;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_draw;

    draw_tracker tracker = new();

    int unsigned sender_calm = 0;

    xoshiro256pp_generator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_seed_value (i_seed_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_draw       (o_draw)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Seeds lean toward edge values: zero, all ones, one hot, and the value
    // that wraps the first splitmix64 increment to zero.
    function automatic t_word pick_seed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return t_word'(1) << $urandom_range(0, WordW - 1);
            3: return t_word'(0) - GOLDEN_STEP;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Offer one beat after a random gap and hold it until the block takes it.
    task automatic send_beat(input logic op, input t_word seed);
        int unsigned gap;
        if (sender_calm != 0) begin
            sender_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 3) sender_calm = $urandom_range(40, 150);
            gap = pick_gap();
        end
        if (gap != 0) begin
            // Drop valid and scribble on the payload while idle.
            i_valid      <= 1'b0;
            i_operation  <= 1'($urandom());
            i_seed_value <= {$urandom(), $urandom()};
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_seed_value <= seed;
        do @(posedge i_clk); while (o_stall);
        tracker.note_beat(op, seed);
    endtask

    // Stop offering beats until every owed draw has come out.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    // Receiver: check accepted output beats, drive i_stall.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned taken;
        stall_left = 0;
        calm_left  = 0;
        taken      = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                tracker.check_draw(o_draw);
                taken++;
                // Hold off long enough for the block to back up its input.
                if (taken == 150 || taken == 900) stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0) begin
                if (calm_left != 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 99) < 3) begin
                    calm_left = $urandom_range(40, 150);
                end else begin
                    stall_left = pick_gap();
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Sender: reset, directed beats, then the random stream.
    initial begin : sender
        logic op;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_operation  <= OP_DRAW;
        i_seed_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Draws straight out of reset, one carrying an all-ones ignored seed.
        send_beat(OP_DRAW, '0);
        send_beat(OP_DRAW, '1);
        send_beat(OP_DRAW, '0);
        // Reseed with zero must restart the reset sequence.
        send_beat(OP_RESEED, '0);
        send_beat(OP_DRAW, '0);
        send_beat(OP_DRAW, '1);
        send_beat(OP_RESEED, '1);
        send_beat(OP_DRAW, '0);
        send_beat(OP_RESEED, 64'h1);
        send_beat(OP_DRAW, '0);
        send_beat(OP_RESEED, 64'h8000_0000_0000_0000);
        send_beat(OP_DRAW, '0);
        // Wrap the running seed to zero on the first increment.
        send_beat(OP_RESEED, t_word'(0) - GOLDEN_STEP);
        send_beat(OP_DRAW, '0);
        // Back-to-back reseeds: only the last one may count.
        send_beat(OP_RESEED, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(OP_RESEED, 64'h5555_5555_5555_5555);
        send_beat(OP_DRAW, '0);
        send_beat(OP_DRAW, '0);
        send_beat(OP_RESEED, '1);
        send_beat(OP_RESEED, '0);
        send_beat(OP_DRAW, '1);
        drain();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            op = ($urandom_range(0, 99) < 12) ? OP_RESEED : OP_DRAW;
            send_beat(op, (op == OP_RESEED) ? pick_seed() : t_word'({$urandom(), $urandom()}));
            if (n == RANDOM_BEATS / 2) drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        tracker.flag_leftovers();
        if (tracker.mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #12_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/xsr_pkg.sv
rtl/core/xsr_mul64.sv
rtl/core/xsr_ctrl.sv
rtl/core/xoshiro256pp_generator.sv
test/draw_tracker_pkg.sv
test/testbench.sv
